// ===== hw/rtl/rsi_pkg.sv =====
`default_nettype none

package rsi_pkg;

    localparam int FRAC_BITS = 16;

    localparam int CW      = 32;
    localparam int EW      = CW + 1;
    localparam int DD_W    = 2 * CW;
    localparam int DE_W    = CW + EW;
    localparam int AW      = 2 * CW;
    localparam int HW      = DE_W + 1;
    localparam int CM_W    = DE_W;
    localparam int CHI_W   = CM_W - CW;
    localparam int SQ_W    = 2 * CM_W;
    localparam int RAD_W   = CW - 1;
    localparam int RR_W    = 2 * RAD_W;
    localparam int AR_W    = AW + RR_W;
    localparam int DW      = SQ_W + 2;
    localparam int SW      = AR_W / 2;
    localparam int VW      = 2 * SW;
    localparam int RW      = SW + 2;
    localparam int RS_W    = RW + 2;
    localparam int QW      = CW;
    localparam int NUM_W   = HW + 1;
    localparam int MAG_W   = HW;
    localparam int NF_W    = MAG_W + FRAC_BITS;
    localparam int NH_W    = NF_W - QW;
    localparam int CFG_IDX_W = 8;

    localparam int FRONT_STAGES = 8;
    localparam int PREP_STAGES  = 3;
    localparam int LATENCY      = FRONT_STAGES + SW + PREP_STAGES + QW + 1;

    localparam logic [QW-1:0] SAT_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic [QW-1:0] SAT_MIN = {1'b1, {(QW-1){1'b0}}};
    localparam logic [QW-1:0] NO_HIT  = ~(({{(QW-1){1'b0}}, 1'b1} << FRAC_BITS)
                                          - {{(QW-1){1'b0}}, 1'b1});
    localparam logic [RAD_W-1:0] RADIUS_RESET = {{(RAD_W-1){1'b0}}, 1'b1} << FRAC_BITS;

    typedef logic signed [EW-1:0]    t_e;
    typedef logic        [CM_W-1:0]  t_cm;
    typedef logic        [SQ_W-1:0]  t_sqw;
    typedef logic        [AR_W-1:0]  t_ar;
    typedef logic        [DW-1:0]    t_dw;
    typedef logic        [AW-1:0]    t_a;
    typedef logic signed [NUM_W-1:0] t_num;
    typedef logic        [MAG_W-1:0] t_mag;

    // one beat in the square root chain
    typedef struct packed {
        logic                  valid;
        logic                  zd;
        logic                  miss;
        logic [AW-1:0]         a;
        logic signed [HW-1:0]  h;
        logic [VW-1:0]         v;
        logic [RW-1:0]         rem;
        logic [SW-1:0]         root;
    } t_sq;

    // one root in the divider chain
    typedef struct packed {
        logic          neg;
        logic          ovf;
        logic [AW-1:0] rem;
        logic [QW-1:0] lq;
    } t_lane;

    typedef struct packed {
        logic          valid;
        logic          zd;
        logic          miss;
        logic [AW-1:0] a;
        t_lane         ln;
        t_lane         lf;
    } t_dv;

endpackage

`default_nettype wire

// ===== hw/rtl/ray_sphere_intersect.sv =====
`default_nettype none

// Ray / sphere intersection, Q16.16 fixed point.
// Input beat: pulse start with the ray origin and direction on i_origin_* and
// i_dir_*. A beat is taken on every clock edge with start high and busy low;
// busy is low at all times outside reset, so one ray can enter every cycle.
// Result beat: o_valid is high for exactly one cycle with o_near_dist,
// o_far_dist, o_hit_count and o_zero_direction; the receiver cannot stall,
// so results must be taken as they appear.
// Pipeline from start to o_valid: the front stages for the products and the
// discriminant, 63 square root cells (one root bit each), the stages that form
// the numerators, 32 divider cells (one quotient bit each) and the output register.
// Throughput is one ray per cycle, set by the cell chains which hand a beat on
// every clock.
// Configuration: write sphere centre x, y, z (index 0 to 2) and radius (index 3)
// through i_cfg_valid / i_cfg_index / i_cfg_data while no ray is in flight;
// o_cfg_ready is always high and other indexes are dropped.
// Reset (synchronous, active low) empties the pipeline, sets the centre to the
// origin and the radius to 1.0; no clearing pass is needed.
module ray_sphere_intersect (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic signed [rsi_pkg::CW-1:0]         i_origin_x,
    input  wire logic signed [rsi_pkg::CW-1:0]         i_origin_y,
    input  wire logic signed [rsi_pkg::CW-1:0]         i_origin_z,
    input  wire logic signed [rsi_pkg::CW-1:0]         i_dir_x,
    input  wire logic signed [rsi_pkg::CW-1:0]         i_dir_y,
    input  wire logic signed [rsi_pkg::CW-1:0]         i_dir_z,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [rsi_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [rsi_pkg::CW-1:0]                i_cfg_data,
    output logic                                       o_valid,
    output logic signed [rsi_pkg::QW-1:0]              o_near_dist,
    output logic signed [rsi_pkg::QW-1:0]              o_far_dist,
    output logic [1:0]                                 o_hit_count,
    output logic                                       o_zero_direction
);

    typedef enum logic [rsi_pkg::CFG_IDX_W-1:0] {
        CFG_CENTER_X = 0,
        CFG_CENTER_Y = 1,
        CFG_CENTER_Z = 2,
        CFG_RADIUS   = 3
    } t_cfg_idx;

    logic signed [rsi_pkg::CW-1:0]    r_center_x, r_center_y, r_center_z;
    logic [rsi_pkg::RAD_W-1:0]        r_radius;

    logic signed [rsi_pkg::CW-1:0]    w_org [3];
    logic signed [rsi_pkg::CW-1:0]    w_dir [3];
    logic signed [rsi_pkg::CW-1:0]    w_ctr [3];

    rsi_pkg::t_sq                     w_sq [0:rsi_pkg::SW];
    rsi_pkg::t_dv                     w_dv [0:rsi_pkg::QW];

    logic                             r_p1_valid, r_p1_zd, r_p1_miss;
    logic [rsi_pkg::AW-1:0]           r_p1_a;
    logic signed [rsi_pkg::NUM_W-1:0] r_p1_num_n, r_p1_num_f;

    logic                             r_p2_valid, r_p2_zd, r_p2_miss;
    logic [rsi_pkg::AW-1:0]           r_p2_a;
    logic                             r_p2_neg_n, r_p2_neg_f;
    logic [rsi_pkg::MAG_W-1:0]        r_p2_mag_n, r_p2_mag_f;

    logic [rsi_pkg::NF_W-1:0]         n_nn, n_nf;
    rsi_pkg::t_dv                     r_p3;

    logic [rsi_pkg::QW-1:0]           n_tn, n_tf;

    assign busy        = !i_rst_n;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_CENTER_X: begin
                    r_center_x <= i_cfg_data;
                end
                CFG_CENTER_Y: begin
                    r_center_y <= i_cfg_data;
                end
                CFG_CENTER_Z: begin
                    r_center_z <= i_cfg_data;
                end
                CFG_RADIUS: begin
                    r_radius <= i_cfg_data[rsi_pkg::RAD_W-1:0];
                end
                default: begin
                end
            endcase
        end
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_center_z <= '0;
            r_radius   <= rsi_pkg::RADIUS_RESET;
        end
    end

    assign w_org[0] = i_origin_x;
    assign w_org[1] = i_origin_y;
    assign w_org[2] = i_origin_z;
    assign w_dir[0] = i_dir_x;
    assign w_dir[1] = i_dir_y;
    assign w_dir[2] = i_dir_z;
    assign w_ctr[0] = r_center_x;
    assign w_ctr[1] = r_center_y;
    assign w_ctr[2] = r_center_z;

    rsi_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start && !busy),
        .i_org    (w_org),
        .i_dir    (w_dir),
        .i_ctr    (w_ctr),
        .i_radius (r_radius),
        .o_sq     (w_sq[0])
    );

    genvar gk;
    for (gk = 0; gk < rsi_pkg::SW; gk++) begin : g_sqrt
        rsi_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_s     (w_sq[gk]),
            .o_s     (w_sq[gk+1])
        );
    end

    // numerators -h - s and -h + s, then sign and magnitude
    always_ff @(posedge i_clk) begin
        r_p1_valid <= w_sq[rsi_pkg::SW].valid;
        r_p1_zd    <= w_sq[rsi_pkg::SW].zd;
        r_p1_miss  <= w_sq[rsi_pkg::SW].miss;
        r_p1_a     <= w_sq[rsi_pkg::SW].a;
        r_p1_num_n <= -rsi_pkg::t_num'(w_sq[rsi_pkg::SW].h)
                      - rsi_pkg::t_num'(w_sq[rsi_pkg::SW].root);
        r_p1_num_f <= rsi_pkg::t_num'(w_sq[rsi_pkg::SW].root)
                      - rsi_pkg::t_num'(w_sq[rsi_pkg::SW].h);

        r_p2_valid <= r_p1_valid;
        r_p2_zd    <= r_p1_zd;
        r_p2_miss  <= r_p1_miss;
        r_p2_a     <= r_p1_a;
        r_p2_neg_n <= r_p1_num_n[rsi_pkg::NUM_W-1];
        r_p2_neg_f <= r_p1_num_f[rsi_pkg::NUM_W-1];
        r_p2_mag_n <= rsi_pkg::t_mag'(r_p1_num_n[rsi_pkg::NUM_W-1] ? -r_p1_num_n : r_p1_num_n);
        r_p2_mag_f <= rsi_pkg::t_mag'(r_p1_num_f[rsi_pkg::NUM_W-1] ? -r_p1_num_f : r_p1_num_f);
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
        end
    end

    assign n_nn = {r_p2_mag_n, {rsi_pkg::FRAC_BITS{1'b0}}};
    assign n_nf = {r_p2_mag_f, {rsi_pkg::FRAC_BITS{1'b0}}};

    // quotient fits in 32 bits when the upper dividend part is below a
    always_ff @(posedge i_clk) begin
        r_p3.valid  <= r_p2_valid;
        r_p3.zd     <= r_p2_zd;
        r_p3.miss   <= r_p2_miss;
        r_p3.a      <= r_p2_a;
        r_p3.ln.neg <= r_p2_neg_n;
        r_p3.lf.neg <= r_p2_neg_f;
        r_p3.ln.ovf <= rsi_pkg::t_a'(n_nn[rsi_pkg::NF_W-1:rsi_pkg::QW]) >= r_p2_a;
        r_p3.lf.ovf <= rsi_pkg::t_a'(n_nf[rsi_pkg::NF_W-1:rsi_pkg::QW]) >= r_p2_a;
        r_p3.ln.rem <= rsi_pkg::t_a'(n_nn[rsi_pkg::NF_W-1:rsi_pkg::QW]);
        r_p3.lf.rem <= rsi_pkg::t_a'(n_nf[rsi_pkg::NF_W-1:rsi_pkg::QW]);
        r_p3.ln.lq  <= n_nn[rsi_pkg::QW-1:0];
        r_p3.lf.lq  <= n_nf[rsi_pkg::QW-1:0];
        if (!i_rst_n) begin
            r_p3.valid <= 1'b0;
        end
    end

    assign w_dv[0] = r_p3;

    for (gk = 0; gk < rsi_pkg::QW; gk++) begin : g_div
        rsi_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_s     (w_dv[gk]),
            .o_s     (w_dv[gk+1])
        );
    end

    // floor of the signed quotient, saturated
    function automatic logic [rsi_pkg::QW-1:0] root_sat(rsi_pkg::t_lane l);
        logic [rsi_pkg::QW:0]   qi;
        logic [rsi_pkg::QW-1:0] res;
        qi = {1'b0, l.lq} + {{rsi_pkg::QW{1'b0}}, (l.rem != '0)};
        if (l.ovf) begin
            res = l.neg ? rsi_pkg::SAT_MIN : rsi_pkg::SAT_MAX;
        end else if (!l.neg) begin
            res = l.lq[rsi_pkg::QW-1] ? rsi_pkg::SAT_MAX : l.lq;
        end else if (qi[rsi_pkg::QW] || qi[rsi_pkg::QW-1]) begin
            res = rsi_pkg::SAT_MIN;
        end else begin
            res = {rsi_pkg::QW{1'b0}} - qi[rsi_pkg::QW-1:0];
        end
        return res;
    endfunction

    assign n_tn = root_sat(w_dv[rsi_pkg::QW].ln);
    assign n_tf = root_sat(w_dv[rsi_pkg::QW].lf);

    always_ff @(posedge i_clk) begin
        o_valid          <= w_dv[rsi_pkg::QW].valid;
        o_zero_direction <= w_dv[rsi_pkg::QW].zd;
        if (w_dv[rsi_pkg::QW].zd || w_dv[rsi_pkg::QW].miss) begin
            o_near_dist <= rsi_pkg::NO_HIT;
            o_far_dist  <= rsi_pkg::NO_HIT;
            o_hit_count <= 2'd0;
        end else begin
            o_near_dist <= n_tn;
            o_far_dist  <= n_tf;
            o_hit_count <= {1'b0, !n_tn[rsi_pkg::QW-1]} + {1'b0, !n_tf[rsi_pkg::QW-1]};
        end
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end
    end

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, rsi_pkg::LATENCY))
        else $error("result beat without a matching ray");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $signed(o_near_dist) <= $signed(o_far_dist))
        else $error("near root above far root");

    a_zero_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_direction |->
            o_hit_count == 2'd0 && o_near_dist == rsi_pkg::NO_HIT
            && o_far_dist == rsi_pkg::NO_HIT)
        else $error("zero direction not reported as a miss");

    a_two_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit_count == 2'd2 |-> !o_near_dist[rsi_pkg::QW-1])
        else $error("two hits with a negative near root");

endmodule

`default_nettype wire

// ===== hw/rtl/rsi_front.sv =====
`default_nettype none

module rsi_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    input  wire logic signed [rsi_pkg::CW-1:0]   i_org [3],
    input  wire logic signed [rsi_pkg::CW-1:0]   i_dir [3],
    input  wire logic signed [rsi_pkg::CW-1:0]   i_ctr [3],
    input  wire logic [rsi_pkg::RAD_W-1:0]       i_radius,
    output rsi_pkg::t_sq                         o_sq
);

    logic                                r1_valid, r1_zd;
    logic signed [rsi_pkg::CW-1:0]       r1_d [3];
    logic signed [rsi_pkg::EW-1:0]       r1_e [3];

    logic                                r2_valid, r2_zd;
    logic signed [rsi_pkg::DD_W-1:0]     r2_dd [3];
    logic signed [rsi_pkg::DE_W-1:0]     r2_de [3][3];
    logic [rsi_pkg::RR_W-1:0]            r2_rr;

    logic                                r3_valid, r3_zd;
    logic [rsi_pkg::AW-1:0]              r3_a;
    logic signed [rsi_pkg::HW-1:0]       r3_h;
    logic signed [rsi_pkg::HW-1:0]       r3_c [3];
    logic [rsi_pkg::RR_W-1:0]            r3_rr;

    logic                                r4_valid, r4_zd;
    logic [rsi_pkg::AW-1:0]              r4_a;
    logic signed [rsi_pkg::HW-1:0]       r4_h;
    logic [rsi_pkg::CM_W-1:0]            r4_cm [3];
    logic [rsi_pkg::RR_W-1:0]            r4_rr;

    logic                                r5_valid, r5_zd;
    logic [rsi_pkg::AW-1:0]              r5_a;
    logic signed [rsi_pkg::HW-1:0]       r5_h;
    logic [2*rsi_pkg::CW-1:0]            r5_ll [3];
    logic [rsi_pkg::CW+rsi_pkg::CHI_W-1:0] r5_lh [3];
    logic [2*rsi_pkg::CHI_W-1:0]         r5_hh [3];
    logic [2*rsi_pkg::CW-1:0]            r5_p00, r5_p01, r5_p10, r5_p11;

    logic                                r6_valid, r6_zd;
    logic [rsi_pkg::AW-1:0]              r6_a;
    logic signed [rsi_pkg::HW-1:0]       r6_h;
    logic [rsi_pkg::SQ_W-1:0]            r6_sq [3];
    logic [rsi_pkg::AR_W-1:0]            r6_ar;

    logic                                r7_valid, r7_zd;
    logic [rsi_pkg::AW-1:0]              r7_a;
    logic signed [rsi_pkg::HW-1:0]       r7_h;
    logic signed [rsi_pkg::DW-1:0]       r7_t1;
    logic [rsi_pkg::DW-1:0]              r7_t2;

    logic signed [rsi_pkg::DW-1:0]       n_disc;
    rsi_pkg::t_sq                        r_sq;

    // difference and products
    always_ff @(posedge i_clk) begin
        r1_valid <= i_valid;
        r1_zd    <= (i_dir[0] == '0) && (i_dir[1] == '0) && (i_dir[2] == '0);
        for (int i = 0; i < 3; i++) begin
            r1_d[i] <= i_dir[i];
            r1_e[i] <= rsi_pkg::t_e'(i_org[i]) - rsi_pkg::t_e'(i_ctr[i]);
        end
        r2_valid <= r1_valid;
        r2_zd    <= r1_zd;
        for (int i = 0; i < 3; i++) begin
            r2_dd[i] <= r1_d[i] * r1_d[i];
            for (int j = 0; j < 3; j++) begin
                r2_de[i][j] <= r1_d[i] * r1_e[j];
            end
        end
        r2_rr <= i_radius * i_radius;
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end
    end

    // dot products, cross product, magnitudes
    always_ff @(posedge i_clk) begin
        r3_valid <= r2_valid;
        r3_zd    <= r2_zd;
        r3_a     <= r2_dd[0] + r2_dd[1] + r2_dd[2];
        r3_h     <= r2_de[0][0] + r2_de[1][1] + r2_de[2][2];
        r3_c[0]  <= r2_de[1][2] - r2_de[2][1];
        r3_c[1]  <= r2_de[2][0] - r2_de[0][2];
        r3_c[2]  <= r2_de[0][1] - r2_de[1][0];
        r3_rr    <= r2_rr;

        r4_valid <= r3_valid;
        r4_zd    <= r3_zd;
        r4_a     <= r3_a;
        r4_h     <= r3_h;
        r4_rr    <= r3_rr;
        for (int i = 0; i < 3; i++) begin
            r4_cm[i] <= rsi_pkg::t_cm'(r3_c[i][rsi_pkg::HW-1] ? -r3_c[i] : r3_c[i]);
        end
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end
    end

    // partial products of the wide squares and of a*r^2, then their sums
    always_ff @(posedge i_clk) begin
        r5_valid <= r4_valid;
        r5_zd    <= r4_zd;
        r5_a     <= r4_a;
        r5_h     <= r4_h;
        for (int i = 0; i < 3; i++) begin
            r5_ll[i] <= r4_cm[i][rsi_pkg::CW-1:0] * r4_cm[i][rsi_pkg::CW-1:0];
            r5_lh[i] <= r4_cm[i][rsi_pkg::CW-1:0] * r4_cm[i][rsi_pkg::CM_W-1:rsi_pkg::CW];
            r5_hh[i] <= r4_cm[i][rsi_pkg::CM_W-1:rsi_pkg::CW]
                        * r4_cm[i][rsi_pkg::CM_W-1:rsi_pkg::CW];
        end
        r5_p00 <= r4_a[rsi_pkg::CW-1:0] * r4_rr[rsi_pkg::CW-1:0];
        r5_p01 <= r4_a[rsi_pkg::CW-1:0] * r4_rr[rsi_pkg::RR_W-1:rsi_pkg::CW];
        r5_p10 <= r4_a[rsi_pkg::AW-1:rsi_pkg::CW] * r4_rr[rsi_pkg::CW-1:0];
        r5_p11 <= r4_a[rsi_pkg::AW-1:rsi_pkg::CW] * r4_rr[rsi_pkg::RR_W-1:rsi_pkg::CW];

        r6_valid <= r5_valid;
        r6_zd    <= r5_zd;
        r6_a     <= r5_a;
        r6_h     <= r5_h;
        for (int i = 0; i < 3; i++) begin
            r6_sq[i] <= (rsi_pkg::t_sqw'(r5_hh[i]) << (2 * rsi_pkg::CW))
                        + (rsi_pkg::t_sqw'(r5_lh[i]) << (rsi_pkg::CW + 1))
                        + rsi_pkg::t_sqw'(r5_ll[i]);
        end
        r6_ar <= (rsi_pkg::t_ar'(r5_p11) << (2 * rsi_pkg::CW))
                 + ((rsi_pkg::t_ar'(r5_p01) + rsi_pkg::t_ar'(r5_p10)) << rsi_pkg::CW)
                 + rsi_pkg::t_ar'(r5_p00);
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
        end
    end

    // quarter discriminant a*r^2 - |d x e|^2
    assign n_disc = r7_t1 - $signed(r7_t2);

    always_ff @(posedge i_clk) begin
        r7_valid <= r6_valid;
        r7_zd    <= r6_zd;
        r7_a     <= r6_a;
        r7_h     <= r6_h;
        r7_t1    <= $signed(rsi_pkg::t_dw'(r6_ar)) - $signed(rsi_pkg::t_dw'(r6_sq[0]));
        r7_t2    <= rsi_pkg::t_dw'(r6_sq[1]) + rsi_pkg::t_dw'(r6_sq[2]);

        r_sq.valid <= r7_valid;
        r_sq.zd    <= r7_zd;
        r_sq.miss  <= n_disc[rsi_pkg::DW-1];
        r_sq.a     <= r7_a;
        r_sq.h     <= r7_h;
        r_sq.v     <= n_disc[rsi_pkg::VW-1:0];
        r_sq.rem   <= '0;
        r_sq.root  <= '0;
        if (!i_rst_n) begin
            r7_valid   <= 1'b0;
            r_sq.valid <= 1'b0;
        end
    end

    assign o_sq = r_sq;

endmodule

`default_nettype wire

// ===== hw/rtl/rsi_sqrt_cell.sv =====
`default_nettype none

module rsi_sqrt_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire rsi_pkg::t_sq  i_s,
    output rsi_pkg::t_sq       o_s
);

    logic [rsi_pkg::RS_W-1:0] n_rs;
    logic [rsi_pkg::RS_W-1:0] n_trial;
    logic [rsi_pkg::RS_W-1:0] n_diff;
    logic                     n_ge;
    rsi_pkg::t_sq             n_s;
    rsi_pkg::t_sq             r_s;

    // one root bit per cell
    always_comb begin
        n_s     = i_s;
        n_rs    = {i_s.rem, i_s.v[rsi_pkg::VW-1 -: 2]};
        n_trial = {2'b00, i_s.root, 2'b01};
        n_diff  = n_rs - n_trial;
        n_ge    = n_rs >= n_trial;
        n_s.rem  = n_ge ? n_diff[rsi_pkg::RW-1:0] : n_rs[rsi_pkg::RW-1:0];
        n_s.root = {i_s.root[rsi_pkg::SW-2:0], n_ge};
        n_s.v    = {i_s.v[rsi_pkg::VW-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        r_s <= n_s;
        if (!i_rst_n) begin
            r_s.valid <= 1'b0;
        end
    end

    assign o_s = r_s;

endmodule

`default_nettype wire

// ===== hw/rtl/rsi_div_cell.sv =====
`default_nettype none

module rsi_div_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire rsi_pkg::t_dv  i_s,
    output rsi_pkg::t_dv       o_s
);

    rsi_pkg::t_dv n_s;
    rsi_pkg::t_dv r_s;

    // one quotient bit, restoring
    function automatic rsi_pkg::t_lane div_step(rsi_pkg::t_lane l,
                                                logic [rsi_pkg::AW-1:0] a);
        logic [rsi_pkg::AW:0] r2;
        logic [rsi_pkg::AW:0] diff;
        logic                 ge;
        rsi_pkg::t_lane       n;
        n    = l;
        r2   = {l.rem, l.lq[rsi_pkg::QW-1]};
        diff = r2 - {1'b0, a};
        ge   = r2 >= {1'b0, a};
        n.rem = ge ? diff[rsi_pkg::AW-1:0] : r2[rsi_pkg::AW-1:0];
        n.lq  = {l.lq[rsi_pkg::QW-2:0], ge};
        return n;
    endfunction

    always_comb begin
        n_s    = i_s;
        n_s.ln = div_step(i_s.ln, i_s.a);
        n_s.lf = div_step(i_s.lf, i_s.a);
    end

    always_ff @(posedge i_clk) begin
        r_s <= n_s;
        if (!i_rst_n) begin
            r_s.valid <= 1'b0;
        end
    end

    assign o_s = r_s;

endmodule

`default_nettype wire
